// ===== rtl/tick_task_scheduler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Tick task scheduler assertion macros
// Shared shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_TOP_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tick task scheduler check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tick task scheduler check failed");

`endif

// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Table size, derived widths, command and status codes, and the cell control
// bundle shared by the slot cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int IVAL_W     = 16;
  localparam int PEND_W     = 8;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD_PER  = 2'd1,
    CMD_ADD_ONE  = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic              step;
    cmd_t              cmd;
    logic [IVAL_W-1:0] interval;
  } cell_ctl_t;

  // Low three bits of a slot number, as reported on the result channel.
  function automatic logic [2:0] slot3(input logic [31:0] v);
    return v[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tts_cell.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler slot cell
// Holds one slot's countdown, reload value, mode and pending count, and takes
// part in the dispatch priority chain running from slot 0 upward.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tts_pkg::cell_ctl_t         ctl_i,
  input  wire logic                       add_sel_i,
  input  wire logic [tts_pkg::IDX_W-1:0]  cell_idx_i,
  input  wire logic                       pend_i,
  input  wire logic [tts_pkg::IDX_W-1:0]  idx_i,
  output logic                            pend_o,
  output logic [tts_pkg::IDX_W-1:0]       idx_o
);

  logic [tts_pkg::IVAL_W-1:0] countdown_r, countdown_nxt;
  logic [tts_pkg::IVAL_W-1:0] reload_r, reload_nxt;
  logic                       periodic_r, periodic_nxt;
  logic [tts_pkg::PEND_W-1:0] pending_r, pending_nxt;

  logic                       mine;
  logic                       first;
  logic [tts_pkg::IVAL_W-1:0] cd_dec;

  assign mine   = (pending_r != '0);
  assign first  = mine && !pend_i;
  assign pend_o = pend_i || mine;
  assign idx_o  = first ? cell_idx_i : idx_i;
  assign cd_dec = countdown_r - tts_pkg::IVAL_W'(1);

  always_comb begin
    countdown_nxt = countdown_r;
    reload_nxt    = reload_r;
    periodic_nxt  = periodic_r;
    pending_nxt   = pending_r;
    if (ctl_i.step) begin
      unique case (ctl_i.cmd) inside
        tts_pkg::CMD_TICK: begin
          if (periodic_r) begin
            if (cd_dec == '0) begin
              countdown_nxt = reload_r;
              if (pending_r != {tts_pkg::PEND_W{1'b1}}) begin
                pending_nxt = pending_r + tts_pkg::PEND_W'(1);
              end
            end else begin
              countdown_nxt = cd_dec;
            end
          end else if (countdown_r != '0) begin
            countdown_nxt = cd_dec;
            if (cd_dec == '0) begin
              pending_nxt = tts_pkg::PEND_W'(1);
            end
          end
        end
        tts_pkg::CMD_ADD_PER, tts_pkg::CMD_ADD_ONE: begin
          if (add_sel_i) begin
            periodic_nxt  = (ctl_i.cmd == tts_pkg::CMD_ADD_PER);
            reload_nxt    = (ctl_i.cmd == tts_pkg::CMD_ADD_PER) ? ctl_i.interval : '0;
            countdown_nxt = ctl_i.interval;
            pending_nxt   = '0;
          end
        end
        tts_pkg::CMD_DISPATCH: begin
          if (first) begin
            pending_nxt = pending_r - tts_pkg::PEND_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      reload_r    <= '0;
      periodic_r  <= 1'b0;
      pending_r   <= '0;
    end else begin
      countdown_r <= countdown_nxt;
      reload_r    <= reload_nxt;
      periodic_r  <= periodic_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tick_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler top level
// A row of slot cells with a dispatch priority chain and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel carries a command (tick, add periodic
//   slot, add one-shot slot, dispatch) and an interval used by adds.
//   Every accepted request yields exactly one result on the out_ channel:
//   a status, the slot added or granted, and whether any slot is pending.
//   The result is registered and is valid in the cycle after acceptance.
//   Throughput is one request per cycle while out_ready is high; all slot
//   cells update in parallel and the dispatch grant ripples through the
//   cell chain within that cycle.
//   If the receiver stalls, the result register holds and in_ready stays
//   low until it is taken, so the slot state stays frozen meanwhile.
//   Synchronous reset empties the table, clears every countdown and pending
//   count, and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tick_task_scheduler_top_defines.svh"

module tick_task_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_interval,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [2:0]       out_slot_index,
  output logic             out_any_pending
);

  localparam int N = tts_pkg::SLOT_COUNT;

  logic                       accept;
  tts_pkg::cmd_t              cmd;
  tts_pkg::cell_ctl_t         ctl;
  logic [N:0]                 pend_chain;
  logic [tts_pkg::IDX_W-1:0]  idx_chain [0:N];

  logic [tts_pkg::CNT_W-1:0]  slots_used_r, slots_used_nxt;
  logic                       full;
  logic                       out_valid_r;
  logic [1:0]                 status_r, status_nxt;
  logic [2:0]                 slot_r, slot_nxt;
  logic                       add_ok;
  logic                       dispatch_empty;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cmd      = tts_pkg::cmd_t'(in_cmd);
  assign full     = (slots_used_r == tts_pkg::CNT_W'(N));

  assign add_ok = accept && !full &&
                  ((cmd == tts_pkg::CMD_ADD_PER) || (cmd == tts_pkg::CMD_ADD_ONE));
  assign dispatch_empty = accept && (cmd == tts_pkg::CMD_DISPATCH) && !pend_chain[N];

  assign ctl.step     = accept;
  assign ctl.cmd      = cmd;
  assign ctl.interval = in_interval;

  assign pend_chain[0] = 1'b0;
  assign idx_chain[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    tts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .add_sel_i  (slots_used_r == tts_pkg::CNT_W'(k)),
      .cell_idx_i (tts_pkg::IDX_W'(k)),
      .pend_i     (pend_chain[k]),
      .idx_i      (idx_chain[k]),
      .pend_o     (pend_chain[k+1]),
      .idx_o      (idx_chain[k+1])
    );
  end

  always_comb begin
    slots_used_nxt = slots_used_r;
    status_nxt     = tts_pkg::ST_OK;
    slot_nxt       = '0;
    unique case (cmd) inside
      tts_pkg::CMD_TICK: begin
      end
      tts_pkg::CMD_ADD_PER, tts_pkg::CMD_ADD_ONE: begin
        if (full) begin
          status_nxt = tts_pkg::ST_FULL;
        end else begin
          slots_used_nxt = slots_used_r + tts_pkg::CNT_W'(1);
          slot_nxt       = tts_pkg::slot3(32'(slots_used_r));
        end
      end
      tts_pkg::CMD_DISPATCH: begin
        if (pend_chain[N]) begin
          slot_nxt = tts_pkg::slot3(32'(idx_chain[N]));
        end else begin
          status_nxt = tts_pkg::ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      slots_used_r <= '0;
    end else begin
      if (accept) begin
        out_valid_r  <= 1'b1;
        slots_used_r <= slots_used_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
    end
  end

  // The slot state only changes on acceptance, so the pending summary read
  // from the cells stays fixed while a result waits.
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_index  = slot_r;
  assign out_any_pending = pend_chain[N];

  `TTS_ASSERT_NOW(a_used_bound, 1'b1, slots_used_r <= tts_pkg::CNT_W'(N))
  `TTS_ASSERT_NEXT(a_empty_dispatch, dispatch_empty, out_status == tts_pkg::ST_NONE)
  `TTS_ASSERT_NEXT(a_add_grows, add_ok, slots_used_r == $past(slots_used_r) + tts_pkg::CNT_W'(1))
  `TTS_ASSERT_NOW(a_full_report, out_valid_r && (out_status == tts_pkg::ST_FULL), full)

endmodule

`default_nettype wire

// ===== bench/tick_task_scheduler_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick task scheduler testbench
// Drives tick, add and dispatch requests through the valid/ready input,
// predicts every result from a local copy of the slot table, and compares
// each returned result field by field in request order. Random gaps on both
// sides, a long receiver stall and pending count saturation are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler_top_test;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    tts_pkg::status_t status;
    logic [2:0]       slot;
    logic             any_pending;
  } sched_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_interval;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [2:0]  out_slot_index;
  logic        out_any_pending;

  // Local copy of the slot table.
  logic [15:0] timer_left   [tts_pkg::SLOT_COUNT];
  logic [15:0] timer_reload [tts_pkg::SLOT_COUNT];
  logic        slot_periodic[tts_pkg::SLOT_COUNT];
  logic [7:0]  runs_owed    [tts_pkg::SLOT_COUNT];
  int          slots_filled;

  sched_result_t due_results[$];
  int            error_count;
  int            cycle_count;
  bit            gaps_on;
  int            hold_cycles;

  tick_task_scheduler_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_interval    (in_interval),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_any_pending(out_any_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one request to the local table and returns the result it yields.
  function automatic sched_result_t schedule_step(input tts_pkg::cmd_t cmd,
                                                  input logic [15:0] ival);
    sched_result_t r;
    bit            granted;
    r.status      = tts_pkg::ST_OK;
    r.slot        = 3'd0;
    r.any_pending = 1'b0;
    granted       = 1'b0;
    case (cmd)
      tts_pkg::CMD_TICK: begin
        for (int k = 0; k < slots_filled; k++) begin
          if (slot_periodic[k]) begin
            timer_left[k] = timer_left[k] - 16'd1;
            if (timer_left[k] == 16'd0) begin
              if (runs_owed[k] != 8'hFF) runs_owed[k] = runs_owed[k] + 8'd1;
              timer_left[k] = timer_reload[k];
            end
          end else if (timer_left[k] != 16'd0) begin
            timer_left[k] = timer_left[k] - 16'd1;
            if (timer_left[k] == 16'd0) runs_owed[k] = 8'd1;
          end
        end
      end
      tts_pkg::CMD_ADD_PER, tts_pkg::CMD_ADD_ONE: begin
        if (slots_filled >= tts_pkg::SLOT_COUNT) begin
          r.status = tts_pkg::ST_FULL;
        end else begin
          slot_periodic[slots_filled] = (cmd == tts_pkg::CMD_ADD_PER);
          timer_reload[slots_filled]  = (cmd == tts_pkg::CMD_ADD_PER) ? ival : 16'd0;
          timer_left[slots_filled]    = ival;
          runs_owed[slots_filled]     = 8'd0;
          r.slot                      = 3'(slots_filled);
          slots_filled++;
        end
      end
      default: begin
        r.status = tts_pkg::ST_NONE;
        for (int k = 0; k < slots_filled; k++) begin
          if (!granted && runs_owed[k] != 8'd0) begin
            runs_owed[k] = runs_owed[k] - 8'd1;
            r.status     = tts_pkg::ST_OK;
            r.slot       = 3'(k);
            granted      = 1'b1;
          end
        end
      end
    endcase
    for (int k = 0; k < slots_filled; k++) begin
      if (runs_owed[k] != 8'd0) r.any_pending = 1'b1;
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input tts_pkg::cmd_t cmd, input logic [15:0] ival);
    int gap;
    gap = gaps_on ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_interval <= ival;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(schedule_step(cmd, ival));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(tts_pkg::CMD_DISPATCH, 16'hFFFF);
    send_request(tts_pkg::CMD_TICK, 16'h0000);
    send_request(tts_pkg::CMD_DISPATCH, 16'h5A5A);
    wait_for_results();
  endtask

  task automatic test_first_slots();
    send_request(tts_pkg::CMD_ADD_PER, 16'd1);
    send_request(tts_pkg::CMD_TICK, 16'hFFFF);
    send_request(tts_pkg::CMD_DISPATCH, 16'h0000);
    send_request(tts_pkg::CMD_DISPATCH, 16'hA5A5);
    // A one-shot slot with no interval must never become pending.
    send_request(tts_pkg::CMD_ADD_ONE, 16'd0);
    // A periodic slot with no interval fires only after a full wrap.
    send_request(tts_pkg::CMD_ADD_PER, 16'd0);
    send_request(tts_pkg::CMD_ADD_ONE, 16'd3);
    send_request(tts_pkg::CMD_ADD_PER, 16'hFFFF);
    repeat (3) send_request(tts_pkg::CMD_TICK, 16'($urandom));
    repeat (2) send_request(tts_pkg::CMD_DISPATCH, 16'($urandom));
    wait_for_results();
  endtask

  task automatic test_fill_table();
    send_request(tts_pkg::CMD_ADD_PER, 16'($urandom_range(12, 2)));
    send_request(tts_pkg::CMD_ADD_ONE, 16'($urandom_range(40, 1)));
    send_request(tts_pkg::CMD_ADD_PER, 16'($urandom_range(12, 2)));
    send_request(tts_pkg::CMD_ADD_PER, 16'hFFFF);
    send_request(tts_pkg::CMD_ADD_ONE, 16'h0000);
    wait_for_results();
  endtask

  task automatic test_pending_saturation();
    repeat (280) send_request(tts_pkg::CMD_TICK, 16'($urandom));
    repeat (4) send_request(tts_pkg::CMD_DISPATCH, 16'($urandom));
    wait_for_results();
  endtask

  task automatic test_backpressure();
    tts_pkg::cmd_t cmd;
    gaps_on     = 1'b0;
    hold_cycles = 60;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) cmd = tts_pkg::CMD_DISPATCH;
      else            cmd = tts_pkg::CMD_TICK;
      send_request(cmd, 16'($urandom));
    end
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int            pick;
    tts_pkg::cmd_t cmd;
    for (int n = 0; n < 330; n++) begin
      if (n % 55 == 0) gaps_on = ~gaps_on;
      pick = $urandom_range(99, 0);
      if (pick < 42)      cmd = tts_pkg::CMD_TICK;
      else if (pick < 88) cmd = tts_pkg::CMD_DISPATCH;
      else if (pick < 94) cmd = tts_pkg::CMD_ADD_PER;
      else                cmd = tts_pkg::CMD_ADD_ONE;
      send_request(cmd, 16'($urandom));
    end
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= tts_pkg::CMD_TICK;
    in_interval <= 16'd0;
    error_count  = 0;
    gaps_on      = 1'b1;
    hold_cycles  = 0;
    slots_filled = 0;
    for (int k = 0; k < tts_pkg::SLOT_COUNT; k++) begin
      timer_left[k]    = 16'd0;
      timer_reload[k]  = 16'd0;
      slot_periodic[k] = 1'b0;
      runs_owed[k]     = 8'd0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_first_slots();
    test_fill_table();
    test_pending_saturation();
    test_backpressure();
    test_random_mix();

    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("** tick_task_scheduler_top: PASSED **");
    end else begin
      $display("** tick_task_scheduler_top: FAILED **");
    end
    $finish;
  end

  // Result side: a random stall before each result, or a long one on demand.
  initial begin : result_receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(9, 0) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    sched_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result returned with no request outstanding");
        error_count++;
      end else begin
        exp = due_results.pop_front();
        if (out_status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_status);
          error_count++;
        end
        if (out_slot_index !== exp.slot) begin
          $error("slot_index: expected %0d, got %0d", exp.slot, out_slot_index);
          error_count++;
        end
        if (out_any_pending !== exp.any_pending) begin
          $error("any_pending: expected %0d, got %0d", exp.any_pending, out_any_pending);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** tick_task_scheduler_top: FAILED **");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

`default_nettype wire

// ===== tick_task_scheduler_top.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/tick_task_scheduler_top.sv
bench/tick_task_scheduler_top_test.sv
